// File: rtl/rbcs_pkg.sv
`default_nettype none

package rbcs_pkg;

    // fixed field widths
    localparam int COUNT_BITS = 21;
    localparam int SUM_BITS   = 36;
    localparam int SCORE_BITS = 16;
    localparam int SIZE_BITS  = 11;

    // size register reset value and lower bound
    localparam int SIZE_RESET = 1024;
    localparam int SIZE_MIN   = 3;

    // saturation limits of the accumulators
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [SUM_BITS-1:0]   SUM_MAX   = '1;

    // divider step counter, one quotient bit per cycle
    localparam int DIV_CNT_BITS = $clog2(SUM_BITS + 1);

    // configuration register indexes
    localparam int CFG_IDX_BITS = 2;
    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_IMAGE_HEIGHT = 2'd0;
    localparam t_cfg_idx CFG_IMAGE_WIDTH  = 2'd1;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_DIV,
        S_PUT
    } t_state;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic judge;
        logic div_step;
        logic load_out;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic last_pixel;
        logic div_done;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

// File: rtl/rbcs_ctrl.sv
`default_nettype none

module rbcs_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    input  wire rbcs_pkg::t_stat i_stat,
    output rbcs_pkg::t_cmd     o_cmd,
    output logic               o_in_stall
);

    rbcs_pkg::t_state r_state;
    rbcs_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rbcs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rbcs_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = rbcs_pkg::S_EVAL;
                end
            end
            rbcs_pkg::S_EVAL: begin
                if (i_stat.last_pixel) begin
                    n_state = rbcs_pkg::S_DIV;
                end else begin
                    n_state = rbcs_pkg::S_IDLE;
                end
            end
            rbcs_pkg::S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = rbcs_pkg::S_PUT;
                end
            end
            rbcs_pkg::S_PUT: begin
                if (i_stat.out_free) begin
                    n_state = rbcs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rbcs_pkg::S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            rbcs_pkg::S_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.capture = i_in_valid;
            end
            rbcs_pkg::S_EVAL: begin
                o_cmd.judge = 1'b1;
            end
            rbcs_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
            end
            rbcs_pkg::S_PUT: begin
                o_cmd.load_out = i_stat.out_free;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/rbcs_dpath.sv
`default_nettype none

module rbcs_dpath #(
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_WIDTH  = 1024,
    parameter int VALUE_BITS = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire rbcs_pkg::t_cfg_idx                i_cfg_index,
    input  wire logic [rbcs_pkg::SIZE_BITS-1:0]    i_cfg_data,
    input  wire logic                              i_mask_bit,
    input  wire logic [VALUE_BITS-1:0]             i_contour_value,
    input  wire logic                              i_out_stall,
    input  wire rbcs_pkg::t_cmd                    i_cmd,
    output rbcs_pkg::t_stat                        o_stat,
    output logic                                   o_out_valid,
    output logic [rbcs_pkg::SCORE_BITS-1:0]        o_score,
    output logic [rbcs_pkg::COUNT_BITS-1:0]        o_boundary_count,
    output logic [rbcs_pkg::SUM_BITS-1:0]          o_strength_sum,
    output logic                                   o_has_boundary
);

    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int ENT_W = VALUE_BITS + 2;
    localparam int H_RST = (MAX_HEIGHT < rbcs_pkg::SIZE_RESET) ? MAX_HEIGHT
                                                               : rbcs_pkg::SIZE_RESET;
    localparam int W_RST = (MAX_WIDTH < rbcs_pkg::SIZE_RESET) ? MAX_WIDTH
                                                              : rbcs_pkg::SIZE_RESET;
    localparam int CB    = rbcs_pkg::COUNT_BITS;
    localparam int SB    = rbcs_pkg::SUM_BITS;
    localparam int QB    = rbcs_pkg::SCORE_BITS;
    localparam int DB    = rbcs_pkg::DIV_CNT_BITS;

    // sizes, stored already clamped
    logic [HW-1:0] r_height;
    logic [WW-1:0] r_width;
    logic [31:0]   cfg_wide;
    logic [HW-1:0] height_clamped;
    logic [WW-1:0] width_clamped;
    logic          cfg_hit;

    // scan position and accumulators
    logic [RW-1:0] r_row;
    logic [CW-1:0] r_col;
    logic [CB-1:0] r_count;
    logic [SB-1:0] r_sum;
    logic [CB-1:0] n_count;
    logic [SB-1:0] n_sum;

    // line memory: per row {mask of column c-1, mask of column c-2, value of column c-1}
    logic [ENT_W-1:0] r_line_mem [MAX_HEIGHT];
    logic [ENT_W-1:0] r_ent_cur;
    logic [ENT_W-1:0] r_ent_dn;
    logic             r_up_mask;
    logic             r_pix_mask;
    logic [VALUE_BITS-1:0] r_pix_value;
    logic [RW-1:0]    addr_dn;

    // pixel evaluation
    logic last_row;
    logic last_col;
    logic is_interior;
    logic hit_interior;
    logic hit_border;
    logic [CB:0] count_add;
    logic [SB:0] sum_add;

    // divider
    logic [SB-1:0] r_div_num;
    logic [CB-1:0] r_div_den;
    logic [CB-1:0] r_div_rem;
    logic [QB-1:0] r_div_quo;
    logic [DB-1:0] r_div_cnt;
    logic [CB:0]   rem_shift;
    logic          rem_ge;
    logic [CB:0]   rem_diff;

    // output word
    logic          r_out_valid;
    logic [QB-1:0] r_out_score;
    logic [CB-1:0] r_out_count;
    logic [SB-1:0] r_out_sum;
    logic          r_out_has;

    // size clamping on write
    always_comb begin
        cfg_wide = 32'(i_cfg_data);
        if (cfg_wide < 32'(rbcs_pkg::SIZE_MIN)) begin
            height_clamped = HW'(rbcs_pkg::SIZE_MIN);
        end else if (cfg_wide > 32'(MAX_HEIGHT)) begin
            height_clamped = HW'(MAX_HEIGHT);
        end else begin
            height_clamped = HW'(cfg_wide);
        end
        if (cfg_wide < 32'(rbcs_pkg::SIZE_MIN)) begin
            width_clamped = WW'(rbcs_pkg::SIZE_MIN);
        end else if (cfg_wide > 32'(MAX_WIDTH)) begin
            width_clamped = WW'(MAX_WIDTH);
        end else begin
            width_clamped = WW'(cfg_wide);
        end
    end

    // register index decode
    always_comb begin
        unique case (i_cfg_index)
            rbcs_pkg::CFG_IMAGE_HEIGHT: cfg_hit = i_cfg_we;
            rbcs_pkg::CFG_IMAGE_WIDTH:  cfg_hit = i_cfg_we;
            default:                    cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height <= HW'(H_RST);
            r_width  <= WW'(W_RST);
        end else if (i_cfg_we && i_cfg_index == rbcs_pkg::CFG_IMAGE_HEIGHT) begin
            r_height <= height_clamped;
        end else if (i_cfg_we && i_cfg_index == rbcs_pkg::CFG_IMAGE_WIDTH) begin
            r_width <= width_clamped;
        end
    end

    // position flags
    assign last_row = (HW'(r_row) + HW'(1)) == r_height;
    assign last_col = (WW'(r_col) + WW'(1)) == r_width;
    assign addr_dn  = last_row ? '0 : r_row + RW'(1);

    // line memory read on capture, write back on evaluation
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ent_cur   <= r_line_mem[r_row];
            r_ent_dn    <= r_line_mem[addr_dn];
            r_pix_mask  <= i_mask_bit;
            r_pix_value <= i_contour_value;
        end
        if (i_cmd.judge) begin
            r_line_mem[r_row] <= {r_pix_mask, r_ent_cur[ENT_W-1], r_pix_value};
            r_up_mask         <= r_ent_cur[ENT_W-1];
        end
    end

    // judge interior pixel one column back, and the border pixel at hand
    always_comb begin
        is_interior  = (WW'(r_col) >= WW'(2)) && (r_row != '0) && !last_row;
        hit_interior = is_interior && r_ent_cur[ENT_W-1] &&
                       ((r_ent_cur[ENT_W-2] != r_pix_mask) ||
                        (r_up_mask != r_ent_dn[ENT_W-1]));
        hit_border   = r_pix_mask &&
                       ((r_col == '0) || last_col || (r_row == '0) || last_row);
        count_add = {1'b0, r_count} + (CB+1)'(hit_interior) + (CB+1)'(hit_border);
        sum_add   = {1'b0, r_sum} +
                    (hit_interior ? (SB+1)'(r_ent_cur[VALUE_BITS-1:0]) : '0);
        n_count = (count_add > (CB+1)'(rbcs_pkg::COUNT_MAX)) ? rbcs_pkg::COUNT_MAX
                                                             : count_add[CB-1:0];
        n_sum   = (sum_add > (SB+1)'(rbcs_pkg::SUM_MAX)) ? rbcs_pkg::SUM_MAX
                                                         : sum_add[SB-1:0];
    end

    // position and accumulator update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            r_row   <= '0;
            r_col   <= '0;
            r_count <= '0;
            r_sum   <= '0;
        end else if (i_cmd.judge) begin
            if (!last_row) begin
                r_row <= r_row + RW'(1);
            end else begin
                r_row <= '0;
                r_col <= last_col ? '0 : r_col + CW'(1);
            end
            if (last_row && last_col) begin
                r_count <= '0;
                r_sum   <= '0;
            end else begin
                r_count <= n_count;
                r_sum   <= n_sum;
            end
        end
    end

    // restoring divide step
    always_comb begin
        rem_shift = {r_div_rem, r_div_num[SB-1]};
        rem_ge    = rem_shift >= {1'b0, r_div_den};
        rem_diff  = rem_shift - {1'b0, r_div_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.judge && last_row && last_col) begin
            r_div_cnt <= DB'(SB);
        end else if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt - DB'(1);
        end
    end

    // the dividend rotates, so the full sum is back in place after the last step
    always_ff @(posedge i_clk) begin
        if (i_cmd.judge && last_row && last_col) begin
            r_div_num <= n_sum;
            r_div_den <= n_count;
            r_div_rem <= '0;
            r_div_quo <= '0;
        end else if (i_cmd.div_step) begin
            r_div_num <= {r_div_num[SB-2:0], r_div_num[SB-1]};
            r_div_rem <= rem_ge ? rem_diff[CB-1:0] : rem_shift[CB-1:0];
            r_div_quo <= {r_div_quo[QB-2:0], rem_ge};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_score <= (r_div_den == '0) ? '0 : r_div_quo;
            r_out_count <= r_div_den;
            r_out_sum   <= r_div_num;
            r_out_has   <= r_div_den != '0;
        end
    end

    // output word ports
    assign o_out_valid      = r_out_valid;
    assign o_score          = r_out_score;
    assign o_boundary_count = r_out_count;
    assign o_strength_sum   = r_out_sum;
    assign o_has_boundary   = r_out_has;

    // status
    assign o_stat.last_pixel = last_row && last_col;
    assign o_stat.div_done   = r_div_cnt == DB'(1);
    assign o_stat.out_free   = !r_out_valid || !i_out_stall;

endmodule

`default_nettype wire

// File: rtl/region_boundary_contour_score.sv
// channel   | direction | handshake                | payload
// ----------+-----------+--------------------------+------------------------------------------
// pixel in  | input     | i_in_valid / o_in_stall  | i_mask_bit, i_contour_value
// result    | output    | o_out_valid / i_out_stall| o_score, o_boundary_count,
//           |           |                          | o_strength_sum, o_has_boundary
// config    | input     | i_cfg_we                 | i_cfg_index, i_cfg_data
//
// each pixel has a capture state that reads the row's line-memory entries, then an evaluation
// state that judges and writes back; the last pixel of a frame adds a divide (one quotient bit
// per cycle) and a load of the output register; it waits while a previous word is still stalled
// synchronous active-low reset clears the controller, scan position, accumulators and output valid;
// sizes return to 1024 (or MAX_HEIGHT/MAX_WIDTH if smaller), the line memory is not cleared
// a size register write restarts the frame in progress
`default_nettype none

module region_boundary_contour_score #(
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_WIDTH  = 1024,
    parameter int VALUE_BITS = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [rbcs_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [rbcs_pkg::SIZE_BITS-1:0]    i_cfg_data,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic                              i_mask_bit,
    input  wire logic [VALUE_BITS-1:0]             i_contour_value,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [rbcs_pkg::SCORE_BITS-1:0]        o_score,
    output logic [rbcs_pkg::COUNT_BITS-1:0]        o_boundary_count,
    output logic [rbcs_pkg::SUM_BITS-1:0]          o_strength_sum,
    output logic                                   o_has_boundary
);

    rbcs_pkg::t_cmd  cmd;
    rbcs_pkg::t_stat stat;

    // controller
    rbcs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    // datapath
    rbcs_dpath #(
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_WIDTH  (MAX_WIDTH),
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (rbcs_pkg::t_cfg_idx'(i_cfg_index)),
        .i_cfg_data       (i_cfg_data),
        .i_mask_bit       (i_mask_bit),
        .i_contour_value  (i_contour_value),
        .i_out_stall      (i_out_stall),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_out_valid      (o_out_valid),
        .o_score          (o_score),
        .o_boundary_count (o_boundary_count),
        .o_strength_sum   (o_strength_sum),
        .o_has_boundary   (o_has_boundary)
    );

`ifndef ASSERT_OFF
    // an accepted word is always followed by its evaluation cycle
    a_capture_then_judge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.capture |=> (cmd.judge && o_in_stall))
        else $error("pixel capture not followed by evaluation");

    // the output register is never overwritten while a word is held back
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!o_out_valid || !i_out_stall))
        else $error("output word overwritten while stalled");

    // an empty region gives zero score and zero sum
    a_empty_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_has_boundary) |->
            (o_score == '0 && o_strength_sum == '0 && o_boundary_count == '0))
        else $error("empty region word carries nonzero fields");

    // a result only appears after a divide completes
    a_result_after_divide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(cmd.load_out))
        else $error("output word without a finished divide");
`endif

endmodule

`default_nettype wire
